// File: rtl/core/glw_pkg.sv
// Shared types and constants for the grid line walk block.
// No dependencies; compiled first.
package glw_pkg;

  // Default edge length of the square occupancy grid.
  localparam int unsigned GRID_SIZE_DEF = 32;

  // Width of every coordinate field on the command channel.
  localparam int unsigned COORD_W = 5;

  typedef enum logic {
    OP_DRAW  = 1'b0,
    OP_SIGHT = 1'b1
  } opcode_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture a new command
    logic rd_start;  // read the bitmap row of the start cell
    logic step;      // visit current cell, advance the walk
    logic rd_next;   // read the bitmap row of the next cell
    logic block;     // sight hit a set cell
    logic emit;      // load the result register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic start_done;  // start cell equals end cell
    logic hit;         // sight command found a set cell
    logic leave;       // next cell falls outside the grid
    logic next_done;   // next cell is the end cell or visit limit reached
  } dp_status_t;

endpackage

// File: rtl/core/glw_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on glw_pkg.
interface glw_cmd_if;
  import glw_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] start_col;
  logic [COORD_W-1:0] end_row;
  logic [COORD_W-1:0] end_col;

  modport source (
    output valid, opcode, start_row, start_col, end_row, end_col,
    input  ready
  );
  modport sink (
    input  valid, opcode, start_row, start_col, end_row, end_col,
    output ready
  );
endinterface

interface glw_res_if;
  logic valid;
  logic ready;
  logic echoed_opcode;
  logic visible;

  modport source (
    output valid, echoed_opcode, visible,
    input  ready
  );
  modport sink (
    input  valid, echoed_opcode, visible,
    output ready
  );
endinterface

// File: rtl/core/grid_line_walk_draw_and_sight.sv
// Top level of the grid line walk block: draw and line-of-sight commands.
// Depends on glw_pkg, glw_if, glw_ctrl, glw_dp (which holds glw_ram).
//
// The block keeps a GRID_SIZE x GRID_SIZE occupancy bitmap, all clear after
// reset; no clearing pass is needed since each bitmap row carries a valid
// flop and a row never written reads as clear. A command transaction on
// cmd_i gives an opcode (draw or sight) plus start and end cells; the block
// walks from start toward end, choosing column, row or diagonal moves from
// the signs of two cross products that are kept incrementally (adds only).
// Draw sets every visited cell, start included and end excluded; sight stops
// at the first set cell. Exactly one result transaction on res_o follows each
// command, with the opcode echoed and visible (0 for draw). A command walks
// over no cells when start equals end and at most 2*GRID_SIZE otherwise,
// counting the set cell at which a sight stops; the walk advances one cell
// per cycle, paced by the registered row read of the bitmap RAM, with the
// previous cycle's row write forwarded to the read. The next command is
// accepted once the current result has been placed in the output register,
// even if the sink has not yet taken it.
module grid_line_walk_draw_and_sight #(
  parameter int unsigned GRID_SIZE = glw_pkg::GRID_SIZE_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  glw_cmd_if.sink      cmd_i,
  glw_res_if.source    res_o
);
  import glw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: accept, start check, walk loop, result hand-off.
  glw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Walk state, bitmap and result register.
  glw_dp #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .opcode_i        (cmd_i.opcode),
    .start_row_i     (cmd_i.start_row),
    .start_col_i     (cmd_i.start_col),
    .end_row_i       (cmd_i.end_row),
    .end_col_i       (cmd_i.end_col),
    .echoed_opcode_o (res_o.echoed_opcode),
    .visible_o       (res_o.visible)
  );

endmodule

// File: rtl/core/glw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/glw_ctrl.sv
// Controller state machine for the grid line walk.
// Depends on glw_pkg; drives glw_dp through ctrl_cmd_t.
module glw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  glw_pkg::dp_status_t   status_i,
  output glw_pkg::ctrl_cmd_t    cmd_o
);
  import glw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (status_i.start_done) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_start = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_WALK: begin
        if (status_i.hit) begin
          cmd_o.block = 1'b1;
          state_d     = S_DONE;
        end else begin
          cmd_o.step = 1'b1;
          if (status_i.leave || status_i.next_done) begin
            state_d = S_DONE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/glw_dp.sv
// Datapath for the grid line walk: walk position, incremental cross product,
// occupancy bitmap RAM with row valid bits. Depends on glw_pkg and glw_ram.
module glw_dp #(
  parameter int unsigned GRID_SIZE = glw_pkg::GRID_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  glw_pkg::ctrl_cmd_t           cmd_i,
  output glw_pkg::dp_status_t          status_o,
  input  logic                         opcode_i,
  input  logic [glw_pkg::COORD_W-1:0]  start_row_i,
  input  logic [glw_pkg::COORD_W-1:0]  start_col_i,
  input  logic [glw_pkg::COORD_W-1:0]  end_row_i,
  input  logic [glw_pkg::COORD_W-1:0]  end_col_i,
  output logic                         echoed_opcode_o,
  output logic                         visible_o
);
  import glw_pkg::*;

  localparam int unsigned CW    = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int unsigned PW    = CW + 2;      // signed position / delta
  localparam int unsigned EW    = 2 * CW + 4;  // signed cross product
  localparam int unsigned LIMIT = 2 * GRID_SIZE;
  localparam int unsigned SW    = $clog2(LIMIT + 1);

  function automatic logic [CW-1:0] sat_coord(input logic [COORD_W-1:0] v);
    if (int'(v) >= int'(GRID_SIZE)) begin
      return CW'(GRID_SIZE - 1);
    end
    return CW'(v);
  endfunction

  // Command registers
  opcode_e               op_q;
  logic [CW-1:0]         br_q, bc_q;
  logic [CW-1:0]         r_q, c_q;
  logic signed [1:0]     sr_q, sc_q;
  logic signed [PW-1:0]  kr_q, kc_q;   // sr*dc and sc*dr
  logic signed [EW-1:0]  e_q;          // cross product at P1
  logic [SW-1:0]         steps_q;
  logic                  vis_q;
  logic                  out_op_q, out_vis_q;

  // Bitmap access
  logic [GRID_SIZE-1:0]  row_valid_q;
  logic                  fwd_hit_q;
  logic [GRID_SIZE-1:0]  fwd_data_q;
  logic                  rd_valid_q;
  logic [GRID_SIZE-1:0]  rdata;
  logic [GRID_SIZE-1:0]  row_cur;
  logic [GRID_SIZE-1:0]  wdata;
  logic                  we, re;
  logic [CW-1:0]         raddr;

  // Load-time values
  logic [CW-1:0]         ar, ac, br, bc;
  logic signed [PW-1:0]  dr, dc, kr_ld, kc_ld;
  logic signed [1:0]     sr_ld, sc_ld;

  // Step values
  logic signed [PW-1:0]  sr_ext, sc_ext, r_s, c_s, nr_s, nc_s;
  logic signed [EW-1:0]  kr_ext, kc_ext, e2, e_next;
  logic                  e1_zero, e2_zero, col_only, row_only;

  always_comb begin
    ar = sat_coord(start_row_i);
    ac = sat_coord(start_col_i);
    br = sat_coord(end_row_i);
    bc = sat_coord(end_col_i);
    dr = $signed({2'b00, br}) - $signed({2'b00, ar});
    dc = $signed({2'b00, bc}) - $signed({2'b00, ac});
    sr_ld = (br > ar) ? 2'sb01 : ((br < ar) ? 2'sb11 : 2'sb00);
    sc_ld = (bc > ac) ? 2'sb01 : ((bc < ac) ? 2'sb11 : 2'sb00);
    kr_ld = (br > ar) ? dc : ((br < ar) ? -dc : '0);
    kc_ld = (bc > ac) ? dr : ((bc < ac) ? -dr : '0);
  end

  // Next cell from the signs of the cross products at P1 and P2.
  always_comb begin
    sr_ext   = {{CW{sr_q[1]}}, sr_q};
    sc_ext   = {{CW{sc_q[1]}}, sc_q};
    kr_ext   = {{(EW-PW){kr_q[PW-1]}}, kr_q};
    kc_ext   = {{(EW-PW){kc_q[PW-1]}}, kc_q};
    e2       = e_q - kc_ext;
    e1_zero  = (e_q == '0);
    e2_zero  = (e2 == '0);
    col_only = !e1_zero && !e2_zero && (e_q[EW-1] == e2[EW-1]);
    row_only = !e1_zero && !e2_zero && (e_q[EW-1] != e2[EW-1]);
    r_s      = $signed({2'b00, r_q});
    c_s      = $signed({2'b00, c_q});
    nr_s     = col_only ? r_s : (r_s + sr_ext);
    nc_s     = row_only ? c_s : (c_s + sc_ext);
    e_next   = e_q + (col_only ? '0 : kr_ext) - (row_only ? '0 : kc_ext);
  end

  // Row as it stands: a row written in the read cycle is forwarded,
  // a row never written reads as clear.
  always_comb begin
    if (fwd_hit_q) begin
      row_cur = fwd_data_q;
    end else if (rd_valid_q) begin
      row_cur = rdata;
    end else begin
      row_cur = '0;
    end
  end

  assign we    = cmd_i.step && (op_q == OP_DRAW);
  assign wdata = row_cur | ({{(GRID_SIZE-1){1'b0}}, 1'b1} << c_q);
  assign re    = cmd_i.rd_start || cmd_i.rd_next;
  assign raddr = cmd_i.rd_next ? nr_s[CW-1:0] : r_q;

  always_comb begin
    status_o            = '0;
    status_o.start_done = (r_q == br_q) && (c_q == bc_q);
    status_o.hit        = (op_q == OP_SIGHT) && row_cur[c_q];
    status_o.leave      = (nr_s < 0) || (nr_s > $signed(PW'(GRID_SIZE - 1)))
                       || (nc_s < 0) || (nc_s > $signed(PW'(GRID_SIZE - 1)));
    status_o.next_done  = ((nr_s[CW-1:0] == br_q) && (nc_s[CW-1:0] == bc_q))
                       || (steps_q >= SW'(LIMIT - 1));
  end

  glw_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (r_q),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (we) begin
      row_valid_q[r_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      fwd_hit_q  <= we && (r_q == raddr);
      fwd_data_q <= wdata;
      rd_valid_q <= row_valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_e'(opcode_i);
      br_q    <= br;
      bc_q    <= bc;
      r_q     <= ar;
      c_q     <= ac;
      sr_q    <= sr_ld;
      sc_q    <= sc_ld;
      kr_q    <= kr_ld;
      kc_q    <= kc_ld;
      e_q     <= {{(EW-PW){kr_ld[PW-1]}}, kr_ld};
      steps_q <= '0;
      vis_q   <= 1'b1;
    end else begin
      if (cmd_i.step) begin
        steps_q <= steps_q + SW'(1);
        if (!status_o.leave) begin
          r_q <= nr_s[CW-1:0];
          c_q <= nc_s[CW-1:0];
          e_q <= e_next;
        end
      end
      if (cmd_i.block) begin
        vis_q <= 1'b0;
      end
    end
    if (cmd_i.emit) begin
      out_op_q  <= op_q;
      out_vis_q <= (op_q == OP_SIGHT) ? vis_q : 1'b0;
    end
  end

  assign echoed_opcode_o = out_op_q;
  assign visible_o       = out_vis_q;

endmodule

// File: tb/tb_grid_line_walk_draw_and_sight.sv
// Self-checking testbench for grid_line_walk_draw_and_sight: draw and sight commands
// are checked against an in-bench walk predictor, with random idling and back-pressure.
// Depends on glw_pkg, glw_if and the RTL of the block.
`timescale 1ns / 1ps

typedef struct packed {
  glw_pkg::opcode_e op;
  logic [4:0]       start_row;
  logic [4:0]       start_col;
  logic [4:0]       end_row;
  logic [4:0]       end_col;
} walk_cmd_t;

typedef struct packed {
  glw_pkg::opcode_e op;
  logic             visible;
} walk_result_t;

// Keeps a private copy of the occupancy bitmap, walks every accepted command
// through it and queues the result the block must return.
class walk_scoreboard;
  localparam int GRID = glw_pkg::GRID_SIZE_DEF;

  bit           cell_set [GRID][GRID];
  int           last_row;
  int           last_col;
  walk_result_t expected_q [$];
  int           errors;

  function new();
    foreach (cell_set[r, c]) cell_set[r][c] = 1'b0;
    last_row = 0;
    last_col = 0;
    errors   = 0;
  endfunction

  function int sgn(int v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Walk from start toward end, drawing or probing each visited cell.
  function void note_command(walk_cmd_t cmd);
    int ar, ac, br, bc, dr, dc, sr, sc, r, c, steps;
    int p1r, p1c, p2c, s1, s2, nr, nc;
    bit clear_path;
    walk_result_t res;
    // 5-bit coordinates never exceed the grid at the default size
    ar = cmd.start_row;
    ac = cmd.start_col;
    br = cmd.end_row;
    bc = cmd.end_col;
    dr = br - ar;
    dc = bc - ac;
    sr = sgn(dr);
    sc = sgn(dc);
    r  = ar;
    c  = ac;
    steps = 0;
    clear_path = 1'b1;
    while ((r != br || c != bc) && steps < 2 * GRID) begin
      if (cmd.op == glw_pkg::OP_DRAW) begin
        cell_set[r][c] = 1'b1;
      end else if (cell_set[r][c]) begin
        clear_path = 1'b0;
        break;
      end
      steps++;
      p1r = r + sr - ar;
      p1c = c - ac;
      p2c = p1c + sc;
      s1  = sgn(p1r * dc - p1c * dr);
      s2  = sgn(p1r * dc - p2c * dr);
      nr  = r;
      nc  = c;
      if (s1 != 0 && s2 != 0 && s1 == s2) begin
        nc = c + sc;
      end else if (s1 != 0 && s2 != 0) begin
        nr = r + sr;
      end else begin
        nr = r + sr;
        nc = c + sc;
      end
      if (nr < 0 || nr >= GRID || nc < 0 || nc >= GRID) break;
      r = nr;
      c = nc;
    end
    last_row = r;
    last_col = c;
    res.op      = cmd.op;
    res.visible = (cmd.op == glw_pkg::OP_SIGHT) ? clear_path : 1'b0;
    expected_q.push_back(res);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 50) $display("walk check: %s", msg);
  endtask

  task check_result(logic echoed_opcode, logic visible);
    walk_result_t exp_res;
    if (expected_q.size() == 0) begin
      report($sformatf("result op=%0b vis=%0b with nothing outstanding", echoed_opcode,
                       visible));
    end else begin
      exp_res = expected_q.pop_front();
      if (echoed_opcode !== exp_res.op)
        report($sformatf("echoed_opcode %0b, expected %0b", echoed_opcode, exp_res.op));
      if (visible !== exp_res.visible)
        report($sformatf("visible %0b, expected %0b (op %0b)", visible, exp_res.visible,
                         exp_res.op));
    end
  endtask
endclass

module tb_grid_line_walk_draw_and_sight;
  import glw_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int HOLD_CYCLES  = 400;   // long sink hold-off, fills the block
  localparam int TAIL_CYCLES  = 80;    // beyond worst-case latency of a command

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  glw_cmd_if cmd_bus ();
  glw_res_if res_bus ();

  grid_line_walk_draw_and_sight #(
    .GRID_SIZE(GRID_SIZE_DEF)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  walk_scoreboard sb = new();

  // Shared between sender and receiver processes
  bit calm;           // no idling on either side
  bit hold_request;   // sender asks the receiver for a long hold-off

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Generous fixed limit, far above the slowest legal run.
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic walk_cmd_t mk_cmd(opcode_e op, int ar, int ac, int br, int bc);
    walk_cmd_t cmd;
    cmd.op        = op;
    cmd.start_row = ar[4:0];
    cmd.start_col = ac[4:0];
    cmd.end_row   = br[4:0];
    cmd.end_col   = bc[4:0];
    return cmd;
  endfunction

  // Coordinate within a few cells of base, kept on the grid.
  function automatic int near(int base);
    int v;
    v = base + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > GRID_SIZE_DEF - 1) v = GRID_SIZE_DEF - 1;
    return v;
  endfunction

  function automatic int pick_gap();
    if (!calm && $urandom_range(0, 3) == 0) return int'($urandom_range(1, 9));
    return 0;
  endfunction

  // Draws are rare and mostly short so the bitmap never fills up and sight
  // results stay mixed; sight lines are split between short and grid-wide.
  function automatic walk_cmd_t make_random_cmd();
    opcode_e op;
    int ar, ac, br, bc;
    int pick;
    op   = ($urandom_range(0, 99) < 8) ? OP_DRAW : OP_SIGHT;
    ar   = $urandom_range(0, GRID_SIZE_DEF - 1);
    ac   = $urandom_range(0, GRID_SIZE_DEF - 1);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      br = ar;
      bc = ac;
    end else if ((op == OP_DRAW && pick < 90) || (op == OP_SIGHT && pick < 40)) begin
      br = near(ar);
      bc = near(ac);
    end else begin
      br = $urandom_range(0, GRID_SIZE_DEF - 1);
      bc = $urandom_range(0, GRID_SIZE_DEF - 1);
    end
    return mk_cmd(op, ar, ac, br, bc);
  endfunction

  // Offer one command after an optional idle gap; returns at the accepting edge.
  // Ready is sampled mid-cycle, where it holds the value seen at the next edge.
  task automatic send_command(input walk_cmd_t cmd, input int gap);
    bit accepted;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.opcode    <= cmd.op;
    cmd_bus.start_row <= cmd.start_row;
    cmd_bus.start_col <= cmd.start_col;
    cmd_bus.end_row   <= cmd.end_row;
    cmd_bus.end_col   <= cmd.end_col;
    do begin
      @(negedge clk_i);
      accepted = (cmd_bus.ready === 1'b1);
      @(posedge clk_i);
    end while (!accepted);
    sb.note_command(cmd);
  endtask

  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: check each transaction, then pick ready for the next cycle.
  initial begin
    int   stall_left;
    int   hold_left;
    bit   fire;
    logic got_op;
    logic got_vis;
    stall_left = 0;
    hold_left  = 0;
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      // handshake and payload sampled mid-cycle, settled on both sides
      @(negedge clk_i);
      fire    = (res_bus.valid === 1'b1) && (res_bus.ready === 1'b1);
      got_op  = res_bus.echoed_opcode;
      got_vis = res_bus.visible;
      @(posedge clk_i);
      if (fire)
        sb.check_result(got_op, got_vis);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        res_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Command side: reset, directed commands, then the random mix.
  initial begin
    int i;
    int gap;
    int burst_left;
    burst_left   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.opcode    <= OP_DRAW;
    cmd_bus.start_row <= '0;
    cmd_bus.start_col <= '0;
    cmd_bus.end_row   <= '0;
    cmd_bus.end_col   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Start equals end: sight on the clear grid, draw that must change nothing
    send_command(mk_cmd(OP_SIGHT, 0, 0, 0, 0), pick_gap());
    send_command(mk_cmd(OP_DRAW, 31, 31, 31, 31), pick_gap());
    // Corner to corner in all four diagonal directions on the empty grid
    send_command(mk_cmd(OP_SIGHT, 0, 0, 31, 31), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 31, 31, 0, 0), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 31, 0, 0, 31), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 0, 31, 31, 0), pick_gap());
    // Full top row; its end cell stays clear
    send_command(mk_cmd(OP_DRAW, 0, 0, 0, 31), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 0, 31, 31, 31), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 0, 4, 20, 4), pick_gap());
    // Bottom row drawn right to left
    send_command(mk_cmd(OP_DRAW, 31, 31, 31, 0), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 31, 0, 0, 0), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 30, 5, 31, 5), pick_gap());
    // Diagonal obstacle, probed across by row, column and anti-diagonal
    send_command(mk_cmd(OP_DRAW, 10, 10, 14, 14), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 12, 8, 12, 20), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 8, 12, 20, 12), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 14, 10, 10, 14), pick_gap());
    // Shallow and steep segments, other octants
    send_command(mk_cmd(OP_DRAW, 5, 20, 9, 29), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 20, 25, 2, 25), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 7, 30, 7, 16), pick_gap());
    send_command(mk_cmd(OP_DRAW, 20, 3, 27, 1), pick_gap());
    send_command(mk_cmd(OP_SIGHT, 25, 0, 25, 8), pick_gap());

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 1000 && i < 1150) || (i >= RANDOM_ITEMS - 200);
      if (i == 300) begin
        // sink holds off while commands keep coming back to back
        hold_request = 1'b1;
        burst_left   = 10;
      end
      if (i == 700) drain_results();
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      send_command(make_random_cmd(), gap);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/glw_pkg.sv
rtl/core/glw_if.sv
rtl/core/glw_ram.sv
rtl/core/glw_ctrl.sv
rtl/core/glw_dp.sv
rtl/core/grid_line_walk_draw_and_sight.sv
tb/tb_grid_line_walk_draw_and_sight.sv
